// File: hdl/multi_stack_shared_store_defines.svh
// assertion macros shared by the multi-stack store rtl
`ifndef MULTI_STACK_SHARED_STORE_DEFINES_SVH
`define MULTI_STACK_SHARED_STORE_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define MSS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mss: assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define MSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mss: assertion failed");

`endif

// File: hdl/mss_pkg.sv
// shared types and codes of the multi-stack store
`timescale 1ns / 1ps
`default_nettype none

package mss_pkg;

    // command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // one input transfer
    typedef struct packed {
        logic               command;
        logic [1:0]         stack_index;
        logic signed [31:0] push_value;
    } t_cmd_item;

    // one result transfer
    typedef struct packed {
        logic signed [31:0] pop_value;
        logic [1:0]         status;
    } t_result;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_COMMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
        logic reject;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic ok;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: hdl/mss_ctrl.sv
// sequencing state machine of the multi-stack store
`timescale 1ns / 1ps
`default_nettype none

module mss_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire mss_pkg::t_dp_stat    i_stat,
    output mss_pkg::t_ctrl_cmd        o_ctrl,
    output logic                      busy
);

    mss_pkg::t_state r_state;
    mss_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        busy    = 1'b1;
        case (r_state)
            mss_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_ctrl.capture = 1'b1;
                    n_state        = mss_pkg::S_LOOK;
                end
            end
            mss_pkg::S_LOOK: begin
                if (i_stat.ok) begin
                    o_ctrl.lookup = 1'b1;
                    n_state       = mss_pkg::S_COMMIT;
                end else begin
                    o_ctrl.reject = 1'b1;
                    n_state       = mss_pkg::S_IDLE;
                end
            end
            mss_pkg::S_COMMIT: begin
                o_ctrl.commit = 1'b1;
                n_state       = mss_pkg::S_IDLE;
            end
            default: begin
                n_state = mss_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/mss_datapath.sv
// head pointers, free list, link and data stores of the multi-stack store
`timescale 1ns / 1ps
`default_nettype none

`include "multi_stack_shared_store_defines.svh"

module mss_datapath #(
    parameter int NUM_STACKS  = 4,
    parameter int STORE_DEPTH = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire mss_pkg::t_cmd_item   i_cmd,
    input  wire mss_pkg::t_ctrl_cmd   i_ctrl,
    output mss_pkg::t_dp_stat         o_stat,
    output logic                      o_done,
    output mss_pkg::t_result          o_result
);

    localparam int PW  = $clog2(STORE_DEPTH);
    localparam int FW  = $clog2(STORE_DEPTH + 1);
    localparam int HW  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int IW  = (HW > 2) ? HW : 2;

    // stores: link entries are {valid, index}; head entries hold the index, valid bits kept apart
    logic [PW-1:0] head_mem [NUM_STACKS];
    logic [PW:0]   link_mem [STORE_DEPTH];
    logic [31:0]   data_mem [STORE_DEPTH];

    logic                  r_head_vld [NUM_STACKS];
    logic [PW:0]           r_free;
    logic [FW-1:0]         r_fill;
    mss_pkg::t_cmd_item    r_cmd;
    logic [HW-1:0]         r_hidx;
    logic [PW-1:0]         r_head_rd;
    logic [PW-1:0]         r_slot;
    logic                  r_fresh;
    logic [PW:0]           r_link_rd;
    logic [31:0]           r_data_rd;
    logic                  r_done;
    mss_pkg::t_result      r_res;

    logic [IW-1:0] w_idx_ext_in;
    logic [HW-1:0] w_hidx_in;
    logic          w_in_range;
    logic          w_is_push;
    logic          w_head_vld;
    logic [PW-1:0] w_slot;
    logic [PW:0]   w_link;
    logic [PW:0]   w_old_head;

    // stack index into head store width
    assign w_idx_ext_in  = IW'(i_cmd.stack_index);
    assign w_hidx_in     = w_idx_ext_in[HW-1:0];
    assign w_in_range    = ({30'd0, r_cmd.stack_index} < 32'(NUM_STACKS));
    assign w_is_push     = (r_cmd.command == mss_pkg::CMD_PUSH);
    assign w_head_vld    = w_in_range && r_head_vld[r_hidx];
    assign w_old_head    = {w_head_vld, r_head_rd};

    // slot chosen by the operation and whether it can go ahead
    assign w_slot    = w_is_push ? r_free[PW-1:0] : r_head_rd;
    assign o_stat.ok = w_in_range && (w_is_push ? r_free[PW] : w_head_vld);

    // entries never handed out take a computed link to the next entry in place of the link store
    assign w_link = r_fresh ? {(r_slot != PW'(STORE_DEPTH - 1)), r_slot + PW'(1)}
                            : r_link_rd;

    // capture the command and read the stack head; write the head back at commit
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_cmd     <= i_cmd;
            r_hidx    <= w_hidx_in;
            r_head_rd <= head_mem[w_hidx_in];
        end
        if (i_ctrl.commit) begin
            head_mem[r_hidx] <= w_is_push ? r_slot : w_link[PW-1:0];
        end
    end

    // link store: read at lookup, rewritten at commit
    always_ff @(posedge i_clk) begin
        if (i_ctrl.lookup) begin
            r_link_rd <= link_mem[w_slot];
            r_slot    <= w_slot;
            r_fresh   <= (FW'(w_slot) >= r_fill);
        end
        if (i_ctrl.commit) begin
            link_mem[r_slot] <= w_is_push ? w_old_head : r_free;
        end
    end

    // data store: read at lookup, written by a push
    always_ff @(posedge i_clk) begin
        if (i_ctrl.lookup) begin
            r_data_rd <= data_mem[w_slot];
        end
        if (i_ctrl.commit && w_is_push) begin
            data_mem[r_slot] <= r_cmd.push_value;
        end
    end

    // control state: head valid bits, free head, fill mark, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_STACKS; i++) begin
                r_head_vld[i] <= 1'b0;
            end
            r_free <= {1'b1, {PW{1'b0}}};
            r_fill <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctrl.commit || i_ctrl.reject;
            if (i_ctrl.commit) begin
                if (w_is_push) begin
                    r_head_vld[r_hidx] <= 1'b1;
                    r_free             <= w_link;
                    if (r_fresh) begin
                        r_fill <= FW'(r_slot) + FW'(1);
                    end
                end else begin
                    r_head_vld[r_hidx] <= w_link[PW];
                    r_free             <= {1'b1, r_slot};
                end
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_ctrl.commit) begin
            r_res.status    <= mss_pkg::ST_DONE;
            r_res.pop_value <= w_is_push ? 32'sd0 : r_data_rd;
        end else if (i_ctrl.reject) begin
            r_res.status    <= w_is_push ? mss_pkg::ST_FULL : mss_pkg::ST_EMPTY;
            r_res.pop_value <= 32'sd0;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    // checks
    `MSS_ASSERT_IMPL(a_done_source, r_done, $past(i_ctrl.commit || i_ctrl.reject))
    `MSS_ASSERT_IMPL(a_fill_bound, 1'b1, r_fill <= FW'(STORE_DEPTH))
    `MSS_ASSERT_NEXT(a_push_reject_full, i_ctrl.reject && w_is_push, r_res.status == mss_pkg::ST_FULL)
    `MSS_ASSERT_NEXT(a_pop_frees_slot, i_ctrl.commit && !w_is_push, r_free[PW])

endmodule

`default_nettype wire

// File: hdl/multi_stack_shared_store.sv
// top level of the multi-stack store: controller plus datapath
// a push or pop that goes ahead passes capture, lookup and commit, then the result strobe is registered
// a refused push or a pop on an empty stack passes capture and reject, then the strobe is registered
// next command is taken in the cycle the strobe shows, not before the last one is through;
// a push or pop does the head read, then the link store read, then the write-back
// synchronous active-low reset empties all stacks and puts every entry on the free list
`timescale 1ns / 1ps
`default_nettype none

module multi_stack_shared_store #(
    parameter int NUM_STACKS  = 4,
    parameter int STORE_DEPTH = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire mss_pkg::t_cmd_item   i_cmd,
    output logic                      busy,
    output logic                      o_done,
    output mss_pkg::t_result          o_result
);

    mss_pkg::t_ctrl_cmd w_ctrl;
    mss_pkg::t_dp_stat  w_stat;

    // sequencer
    mss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .busy    (busy)
    );

    // stores and pointers
    mss_datapath #(
        .NUM_STACKS  (NUM_STACKS),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_ctrl   (w_ctrl),
        .o_stat   (w_stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
